[design/b2da_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// b2da_pkg
// Shared types and constants for the binary to decimal ASCII converter.
// ---------------------------------------------------------------------------
package b2da_pkg;

	// decimal digits kept in the bcd register, enough for a 64-bit word
	localparam int DIGITS = 20;
	// magnitude bits folded into the bcd register per conversion step
	localparam int STEP_BITS = 4;
	localparam int CNT_W = 5;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	// conversion mode carried on func
	localparam logic FUNC_SIGNED   = 1'b0;
	localparam logic FUNC_UNSIGNED = 1'b1;

	typedef logic [DIGITS-1:0][3:0] bcd_t;
	typedef logic [CNT_W-1:0] count_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CONV,
		S_FIND,
		S_EMIT
	} state_t;

endpackage
`default_nettype wire

[design/b2da_dabble.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// b2da_dabble
// Shift-add-3 unit: folds four magnitude bits, msb first, into the bcd word.
// ---------------------------------------------------------------------------
module b2da_dabble (
	input  wire b2da_pkg::bcd_t                      bcd,
	input  wire logic [b2da_pkg::STEP_BITS-1:0]      bits,
	output b2da_pkg::bcd_t                           bcd_next
);

	always_comb begin
		b2da_pkg::bcd_t b;
		logic [b2da_pkg::DIGITS*4-1:0] flat;
		b = bcd;
		flat = '0;
		for (int s = 0; s < b2da_pkg::STEP_BITS; s++) begin
			for (int i = 0; i < b2da_pkg::DIGITS; i++) begin
				if (b[i] >= 4'd5) begin
					b[i] = b[i] + 4'd3;
				end
			end
			flat = b;
			b = {flat[b2da_pkg::DIGITS*4-2:0], bits[b2da_pkg::STEP_BITS-1-s]};
		end
		bcd_next = b;
	end

endmodule
`default_nettype wire

[design/b2da_digits.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// b2da_digits
// Significant digit count of a bcd word: index of the top nonzero digit
// plus one, at least one so that zero prints as a single digit.
// ---------------------------------------------------------------------------
module b2da_digits (
	input  wire b2da_pkg::bcd_t     bcd,
	output b2da_pkg::count_t        ndig
);

	always_comb begin
		ndig = b2da_pkg::count_t'(1);
		for (int i = 1; i < b2da_pkg::DIGITS; i++) begin
			if (bcd[i] != 4'd0) begin
				ndig = b2da_pkg::count_t'(i + 1);
			end
		end
	end

endmodule
`default_nettype wire

[design/binary_to_decimal_ascii.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts one word to decimal ASCII text, one character per transfer.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes func (0 signed, 1 unsigned) and
//   value; only the low VALUE_WIDTH bits of value are used.
//   Output channel (out_valid/out_ready) gives one character per transfer,
//   '-' first for a negative signed value, then digits msb first with no
//   leading zeros. last marks the final character, which also carries
//   char_count; char_count is 0 on the other characters.
//   Timing: in the cycle after the input transfer the shift-add-3 unit
//   folds four bits per cycle into a bcd register until every bit of the
//   magnitude is folded in, then the S_FIND state finds the digit count,
//   then one character per cycle while out_ready is high.
//   in_ready is high only while no item is in the block.
//   A stalled receiver holds the current character stable; the block waits.
//   Reset clears the sequencer; the block comes out idle and ready.
// ---------------------------------------------------------------------------
module binary_to_decimal_ascii #(
	parameter int VALUE_WIDTH = 64
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic                    func,
	input  wire logic [63:0]             value,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [7:0]                   char_out,
	output logic                         last,
	output logic [4:0]                   char_count
);

	localparam int MAG_W = ((VALUE_WIDTH + b2da_pkg::STEP_BITS - 1) / b2da_pkg::STEP_BITS)
		* b2da_pkg::STEP_BITS;
	localparam int STEPS = MAG_W / b2da_pkg::STEP_BITS;
	localparam int STEP_W = $clog2(STEPS);

	b2da_pkg::state_t state_q, state_d;

	logic [MAG_W-1:0]        mag_q;
	logic [STEP_W-1:0]       step_q;
	b2da_pkg::bcd_t          bcd_q;
	b2da_pkg::bcd_t          bcd_next;
	b2da_pkg::count_t        ndig;
	b2da_pkg::count_t        idx_q;
	b2da_pkg::count_t        total_q;
	logic                    neg_q;

	logic [VALUE_WIDTH-1:0]  word;
	logic                    neg_in;
	logic [VALUE_WIDTH-1:0]  mag_in;
	logic                    in_xfer;
	logic                    out_xfer;

	assign word    = value[VALUE_WIDTH-1:0];
	assign neg_in  = (func == b2da_pkg::FUNC_SIGNED) && word[VALUE_WIDTH-1];
	assign mag_in  = neg_in ? (~word + VALUE_WIDTH'(1)) : word;
	assign in_xfer = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	b2da_dabble u_dabble (
		.bcd      (bcd_q),
		.bits     (mag_q[MAG_W-1 -: b2da_pkg::STEP_BITS]),
		.bcd_next (bcd_next)
	);

	b2da_digits u_digits (
		.bcd  (bcd_q),
		.ndig (ndig)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= b2da_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		char_out  = b2da_pkg::CHAR_ZERO;
		last      = 1'b0;
		char_count = 5'd0;
		case (state_q)
			b2da_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = b2da_pkg::S_CONV;
				end
			end
			b2da_pkg::S_CONV: begin
				if (step_q == '0) begin
					state_d = b2da_pkg::S_FIND;
				end
			end
			b2da_pkg::S_FIND: begin
				state_d = b2da_pkg::S_EMIT;
			end
			b2da_pkg::S_EMIT: begin
				out_valid = 1'b1;
				if (neg_q) begin
					char_out = b2da_pkg::CHAR_MINUS;
				end else begin
					char_out = b2da_pkg::CHAR_ZERO | {4'd0, bcd_q[idx_q]};
					last = (idx_q == '0);
					char_count = last ? total_q : 5'd0;
				end
				if (out_ready && last) begin
					state_d = b2da_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = b2da_pkg::S_IDLE;
			end
		endcase
	end

	// neg_q and step_q are sequencer state; bcd and magnitude are payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q  <= 1'b0;
			step_q <= '0;
			idx_q  <= '0;
		end else begin
			if (in_xfer) begin
				neg_q  <= neg_in;
				step_q <= STEP_W'(STEPS - 1);
			end else if (state_q == b2da_pkg::S_CONV) begin
				step_q <= step_q - STEP_W'(1);
			end else if (state_q == b2da_pkg::S_FIND) begin
				idx_q <= ndig - b2da_pkg::count_t'(1);
			end else if (out_xfer) begin
				if (neg_q) begin
					neg_q <= 1'b0;
				end else if (!last) begin
					idx_q <= idx_q - b2da_pkg::count_t'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mag_q <= MAG_W'(mag_in);
			bcd_q <= '0;
		end else if (state_q == b2da_pkg::S_CONV) begin
			mag_q <= mag_q << b2da_pkg::STEP_BITS;
			bcd_q <= bcd_next;
		end
		if (state_q == b2da_pkg::S_FIND) begin
			total_q <= ndig + b2da_pkg::count_t'(neg_q);
		end
	end

`ifndef ASSERT_OFF
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output handshakes active together");

	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready && !out_valid)
		else $error("block not busy after input transfer");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && last |=> in_ready)
		else $error("block not idle after final character");

	a_count_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (char_count != 5'd0)))
		else $error("char_count does not match last");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_out == b2da_pkg::CHAR_MINUS |-> !last)
		else $error("minus sign marked as final character");
`endif

endmodule
`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Checks binary_to_decimal_ascii against its own decimal formatter: every
// number sent is turned into the expected characters, and each character
// transfer on the output is compared with the oldest one still waiting.
// Directed extremes come first, then random numbers under several patterns
// of sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module testbench;

	localparam int VALUE_WIDTH = 64;
	localparam logic MODE_SIGNED   = b2da_pkg::FUNC_SIGNED;
	localparam logic MODE_UNSIGNED = b2da_pkg::FUNC_UNSIGNED;
	localparam int STALL_LIMIT  = 5000;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_ITEMS = 65;

	typedef struct {
		logic [7:0]        ch;
		logic              fin;
		b2da_pkg::count_t  cnt;
	} text_char_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        func;
	logic [63:0] value;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  char_out;
	logic        last;
	logic [4:0]  char_count;

	text_char_t pending_chars[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	binary_to_decimal_ascii #(.VALUE_WIDTH(VALUE_WIDTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.char_out(char_out),
		.last(last),
		.char_count(char_count)
	);

	always #5 clk = ~clk;

	// expected text of one number, pushed character by character
	function automatic void predict_text(input logic mode, input logic [63:0] word);
		logic [63:0] mag;
		logic neg;
		logic [7:0] digs[$];
		text_char_t c;
		int total;
		neg = (mode == MODE_SIGNED) && word[63];
		// wraps to 2^63 for the most negative word, which is the true magnitude
		mag = neg ? (64'd0 - word) : word;
		do begin
			digs.push_front(b2da_pkg::CHAR_ZERO + 8'(mag % 64'd10));
			mag = mag / 64'd10;
		end while (mag != 64'd0);
		total = digs.size() + (neg ? 1 : 0);
		if (neg) begin
			c.ch = b2da_pkg::CHAR_MINUS;
			c.fin = 1'b0;
			c.cnt = '0;
			pending_chars.push_back(c);
		end
		foreach (digs[i]) begin
			c.ch = digs[i];
			c.fin = (i == digs.size() - 1);
			c.cnt = c.fin ? b2da_pkg::count_t'(total) : '0;
			pending_chars.push_back(c);
		end
	endfunction

	function automatic logic [63:0] random_word();
		logic [63:0] w;
		logic [63:0] ten;
		w = {$urandom, $urandom};
		case ($urandom_range(3))
			0: ;
			1: w = w >> $urandom_range(63);
			// small magnitude negatives in signed mode
			2: w = ~(w >> $urandom_range(63));
			default: begin
				ten = 64'd1;
				repeat ($urandom_range(19)) ten = ten * 64'd10;
				w = ten - 64'd1 + 64'($urandom_range(2));
				if ($urandom_range(1))
					w = 64'd0 - w;
			end
		endcase
		return w;
	endfunction

	task automatic send_number(input logic mode, input logic [63:0] word);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			func <= 1'($urandom_range(1));
			value <= {$urandom, $urandom};
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= mode;
		value <= word;
		do @(posedge clk); while (!in_ready);
		predict_text(mode, word);
	endtask

	task automatic send_random_numbers(input int count);
		repeat (count)
			send_number($urandom_range(1) ? MODE_UNSIGNED : MODE_SIGNED, random_word());
	endtask

	// stop sending and let every expected character arrive
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_chars.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic test_extremes();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_number(MODE_SIGNED, 64'd0);
		send_number(MODE_UNSIGNED, 64'd0);
		send_number(MODE_SIGNED, 64'd1);
		send_number(MODE_UNSIGNED, 64'd9);
		send_number(MODE_SIGNED, 64'd10);
		send_number(MODE_SIGNED, '1);
		send_number(MODE_UNSIGNED, '1);
		send_number(MODE_SIGNED, 64'h8000_0000_0000_0000);
		send_number(MODE_UNSIGNED, 64'h8000_0000_0000_0000);
		send_number(MODE_SIGNED, 64'h7FFF_FFFF_FFFF_FFFF);
		send_number(MODE_UNSIGNED, 64'h7FFF_FFFF_FFFF_FFFF);
		send_number(MODE_SIGNED, 64'd0 - 64'd10);
		send_number(MODE_SIGNED, 64'h8000_0000_0000_0001);
		send_number(MODE_UNSIGNED, 64'd10_000_000_000_000_000_000);
		send_number(MODE_UNSIGNED, 64'd9_999_999_999_999_999_999);
		send_number(MODE_SIGNED, 64'd1_000_000_000_000_000_000);
		send_number(MODE_SIGNED, 64'h5555_5555_5555_5555);
		send_number(MODE_UNSIGNED, 64'hAAAA_AAAA_AAAA_AAAA);
		send_number(MODE_SIGNED, 64'hAAAA_AAAA_AAAA_AAAA);
		send_number(MODE_UNSIGNED, 64'h5555_5555_5555_5555);
		wait_drained();
	endtask

	task automatic test_steady_stream();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_random_numbers(RANDOM_ITEMS);
		wait_drained();
	endtask

	task automatic test_sender_gaps();
		send_idle_pct = 78;
		recv_stall_pct = 0;
		send_random_numbers(RANDOM_ITEMS);
		wait_drained();
	endtask

	task automatic test_receiver_stalls();
		send_idle_pct = 0;
		recv_stall_pct = 78;
		send_random_numbers(RANDOM_ITEMS);
		wait_drained();
	endtask

	task automatic test_mixed_gaps();
		send_idle_pct = 37;
		recv_stall_pct = 37;
		send_random_numbers(RANDOM_ITEMS / 2);
		// hold the sender back until the block has emptied
		wait_drained();
		send_random_numbers(RANDOM_ITEMS - RANDOM_ITEMS / 2);
		wait_drained();
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	// compare each output transfer with the oldest expected character
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_chars.size() == 0) begin
				$error("char_out: no character expected, got %h", char_out);
				errors++;
			end else begin
				want = pending_chars.pop_front();
				if (char_out !== want.ch) begin
					$error("char_out: expected %h, got %h", want.ch, char_out);
					errors++;
				end
				if (last !== want.fin) begin
					$error("last: expected %b, got %b", want.fin, last);
					errors++;
				end
				if (char_count !== want.cnt) begin
					$error("char_count: expected %0d, got %0d", want.cnt, char_count);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = MODE_SIGNED;
		value = '0;
		out_ready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_extremes();
		test_steady_stream();
		test_sender_gaps();
		test_receiver_stalls();
		test_mixed_gaps();
		if (errors == 0 && pending_chars.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
